@@ rtl/debr_pkg.sv @@
// shared constants for the double ended buffer with reverse
`timescale 1ns / 1ps
`default_nettype none
package debr_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int ACT_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 40;

    localparam logic [ACT_W-1:0] ACT_DUMP       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REVERSE    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUMP_EMPTY = 2'd3;

endpackage
`default_nettype wire

@@ rtl/double_ended_buffer_with_reverse.sv @@
// top level of the double ended buffer with reverse
`timescale 1ns / 1ps
`default_nettype none
// Deque of up to DEPTH signed 32-bit words kept in a circular memory with a
// front pointer, a fill count and a direction flag, so reverse, push and pop
// all touch a single entry or only the pointers. One command is taken per
// accept and the input is not ready until the command is done. Push, pop and
// reverse take the accept, then one pass through the shared address unit,
// and give one status beat. A dump of N stored words takes the accept, a
// setup step, then for each word the address pass and the registered memory
// read. A dump of an empty store ends at the setup step.
// Any command whose beat finds the output register still held waits for the
// output side, so output stalls hold the command. The output beat sits in
// a register, so the next command can be accepted while it waits. Action
// codes 6 and 7 give no beat.
module double_ended_buffer_with_reverse #(
    parameter int DEPTH = debr_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [debr_pkg::S_DATA_W-1:0] s_tdata,   // action[2:0], value_in[34:3]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [debr_pkg::WORD_W-1:0]   m_tdata,   // value_out[31:0]
    output logic                               m_tlast,
    output logic      [debr_pkg::STATUS_W-1:0] m_tuser    // status[1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_DW   = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [debr_pkg::ACT_W-1:0]        act_reg;
    logic [debr_pkg::WORD_W-1:0]       val_reg;
    logic [AW-1:0]                     head_reg, head_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              rev_reg, rev_next;
    logic [AW-1:0]                     idx_reg, idx_next;
    logic                              out_valid_reg, out_valid_next;
    logic [debr_pkg::WORD_W-1:0]       out_data_reg, out_data_next;
    logic                              out_last_reg, out_last_next;
    logic [debr_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [debr_pkg::WORD_W-1:0]       rd_data_reg;
    logic [debr_pkg::WORD_W-1:0]       mem [DEPTH];

    logic          out_free;
    logic          accept;
    logic          wr_en;
    logic [AW-1:0] u_off;
    logic          u_down;
    logic [AW-1:0] u_addr;
    logic [CW-1:0] count_m1;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign count_m1 = count_reg - CW'(1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    debr_addr_unit #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_addr_unit (
        .base (head_reg),
        .off  (u_off),
        .down (u_down),
        .addr (u_addr)
    );

    // offset and direction for the shared address unit
    always_comb
    begin
        u_off  = idx_reg;
        u_down = rev_reg;
        if (state_reg == S_EXEC)
        begin
            case (act_reg)
                debr_pkg::ACT_PUSH_BACK:
                begin
                    u_off  = count_reg[AW-1:0];
                    u_down = rev_reg;
                end
                debr_pkg::ACT_PUSH_FRONT:
                begin
                    u_off  = AW'(1);
                    u_down = !rev_reg;
                end
                debr_pkg::ACT_POP_FRONT:
                begin
                    u_off  = AW'(1);
                    u_down = rev_reg;
                end
                debr_pkg::ACT_REVERSE:
                begin
                    u_off  = count_m1[AW-1:0];
                    u_down = rev_reg;
                end
                default:
                begin
                    u_off  = idx_reg;
                    u_down = rev_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        wr_en           = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (act_reg == debr_pkg::ACT_DUMP)
                begin
                    idx_next = '0;
                    if (count_reg != '0)
                    begin
                        state_next = S_RD;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        out_status_next = debr_pkg::ST_DUMP_EMPTY;
                        state_next      = S_IDLE;
                    end
                end
                else if (act_reg > debr_pkg::ACT_REVERSE)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = debr_pkg::ST_OK;
                    state_next      = S_IDLE;
                    case (act_reg)
                        debr_pkg::ACT_PUSH_BACK:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                out_status_next = debr_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        debr_pkg::ACT_PUSH_FRONT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                out_status_next = debr_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                head_next  = u_addr;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        debr_pkg::ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = debr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        debr_pkg::ACT_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = debr_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = u_addr;
                                count_next = count_m1;
                            end
                        end
                        debr_pkg::ACT_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                head_next = u_addr;
                                rev_next  = !rev_reg;
                            end
                        end
                        default:
                        begin
                            out_status_next = debr_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_DW;
            end
            S_DW:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rd_data_reg;
                    out_status_next = debr_pkg::ST_OK;
                    if ({1'b0, idx_reg} + (AW+1)'(1) == (AW+1)'(count_reg))
                    begin
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        idx_next      = idx_reg + AW'(1);
                        state_next    = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
        if (accept)
        begin
            act_reg <= s_tdata[debr_pkg::ACT_W-1:0];
            val_reg <= s_tdata[debr_pkg::ACT_W +: debr_pkg::WORD_W];
        end
    end

    // word memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[u_addr] <= val_reg;
        end
        rd_data_reg <= mem[u_addr];
    end

endmodule
`default_nettype wire

@@ rtl/debr_addr_unit.sv @@
// shared circular address unit: base plus or minus offset modulo depth
`timescale 1ns / 1ps
`default_nettype none
module debr_addr_unit #(
    parameter int DEPTH = debr_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic [AW-1:0] base,
    input  wire logic [AW-1:0] off,
    input  wire logic          down,
    output logic      [AW-1:0] addr
);

    localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] dif;

    always_comb
    begin
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        if (base >= off)
        begin
            dif = {1'b0, base} - {1'b0, off};
        end
        else
        begin
            dif = {1'b0, base} + DEPTH_W - {1'b0, off};
        end
        addr = down ? dif[AW-1:0] : sum[AW-1:0];
    end

endmodule
`default_nettype wire

@@ test/debr_checker.sv @@
// checker for the double ended buffer with reverse: predicts and compares result beats
`timescale 1ns / 1ps
module debr_checker #(
    parameter int DEPTH = debr_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [debr_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [debr_pkg::WORD_W-1:0]   m_tdata,
    input  logic                          m_tlast,
    input  logic [debr_pkg::STATUS_W-1:0] m_tuser,
    output int                            errors,
    output int                            pending,
    output int                            commands,
    output int                            beats,
    output int                            full_drops,
    output int                            empty_pops,
    output int                            deepest_fill
);
    import debr_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]   value;
        logic                last;
        logic [STATUS_W-1:0] status;
    } result_beat_t;

    logic [WORD_W-1:0] stored_words[$];
    result_beat_t      expected_beats[$];
    result_beat_t      oldest;

    initial
    begin
        errors       = 0;
        pending      = 0;
        commands     = 0;
        beats        = 0;
        full_drops   = 0;
        empty_pops   = 0;
        deepest_fill = 0;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 20)
            $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic expect_beat(input logic [WORD_W-1:0] value, input logic last,
                               input logic [STATUS_W-1:0] status);
        result_beat_t b;
        b.value  = value;
        b.last   = last;
        b.status = status;
        expected_beats.push_back(b);
    endtask

    // apply one command to the shadow deque and queue its result beats
    task automatic predict_command(input logic [ACT_W-1:0] act,
                                   input logic [WORD_W-1:0] word);
        int n;
        logic [WORD_W-1:0] t;
        n = stored_words.size();
        case (act)
            ACT_DUMP:
                if (n == 0)
                    expect_beat('0, 1'b1, ST_DUMP_EMPTY);
                else
                    for (int i = 0; i < n; i++)
                        expect_beat(stored_words[i], i == n - 1, ST_OK);
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
                if (n >= DEPTH)
                begin
                    full_drops++;
                    expect_beat('0, 1'b1, ST_FULL);
                end
                else
                begin
                    if (act == ACT_PUSH_BACK)
                        stored_words.push_back(word);
                    else
                        stored_words.push_front(word);
                    expect_beat('0, 1'b1, ST_OK);
                end
            ACT_POP_BACK, ACT_POP_FRONT:
                if (n == 0)
                begin
                    empty_pops++;
                    expect_beat('0, 1'b1, ST_EMPTY);
                end
                else
                begin
                    if (act == ACT_POP_BACK)
                        t = stored_words.pop_back();
                    else
                        t = stored_words.pop_front();
                    expect_beat('0, 1'b1, ST_OK);
                end
            ACT_REVERSE:
            begin
                for (int i = 0; i < n / 2; i++)
                begin
                    t = stored_words[i];
                    stored_words[i] = stored_words[n - 1 - i];
                    stored_words[n - 1 - i] = t;
                end
                expect_beat('0, 1'b1, ST_OK);
            end
            default:
                ;
        endcase
        if (stored_words.size() > deepest_fill)
            deepest_fill = stored_words.size();
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                commands++;
                predict_command(s_tdata[ACT_W-1:0], s_tdata[ACT_W+WORD_W-1:ACT_W]);
            end
            if (m_tvalid && m_tready)
            begin
                beats++;
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("beat %0h/%0b/%0d with nothing expected",
                                              m_tdata, m_tlast, m_tuser));
                else
                begin
                    oldest = expected_beats.pop_front();
                    if (m_tdata !== oldest.value)
                        report_mismatch($sformatf("beat %0d value %h, expected %h",
                                                  beats, m_tdata, oldest.value));
                    if (m_tlast !== oldest.last)
                        report_mismatch($sformatf("beat %0d last %b, expected %b",
                                                  beats, m_tlast, oldest.last));
                    if (m_tuser !== oldest.status)
                        report_mismatch($sformatf("beat %0d status %0d, expected %0d",
                                                  beats, m_tuser, oldest.status));
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

@@ test/double_ended_buffer_with_reverse_test.sv @@
// testbench top for the double ended buffer with reverse: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module double_ended_buffer_with_reverse_test;
    import debr_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 232;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [WORD_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;

    int errors, pending, commands, beats, full_drops, empty_pops, deepest_fill;
    int cycles = 0;
    int burst_left = 1;
    int rx_cycle = 0;

    double_ended_buffer_with_reverse dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    debr_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .commands     (commands),
        .beats        (beats),
        .full_drops   (full_drops),
        .empty_pops   (empty_pops),
        .deepest_fill (deepest_fill)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
            $display("[double_ended_buffer_with_reverse] ERROR");
            $finish;
        end
    end

    // receiver: free-flowing, light, random and heavy stall stretches in turn
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            rx_cycle <= rx_cycle + 1;
            case (rx_cycle[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= rx_cycle[1:0] != 2'd3;
                2'd2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= rx_cycle[2:0] == 3'd7;
            endcase
        end
    end

    // present one command and hold it until it is taken, then maybe pause
    task automatic issue(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] word);
        logic ready_seen;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - ACT_W - WORD_W){1'b0}}, word, act};
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        burst_left--;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // fill, balanced and drain phases decide how often pushes win over pops
    task automatic random_command(input int phase, output logic counted);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        push_pct = (phase == 0) ? 65 : (phase == 1) ? 37 : 10;
        counted = 1'b1;
        if (r < 3)
        begin
            counted = 1'b0;
            issue($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO, pick_word());
        end
        else if (r < 15)
            issue(ACT_DUMP, pick_word());
        else if (r < 25)
            issue(ACT_REVERSE, pick_word());
        else if (r < 25 + push_pct)
            issue($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, pick_word());
        else
            issue($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, pick_word());
    endtask

    initial
    begin
        int sent;
        logic counted;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store corner cases, extremes of the word, ignored codes
        issue(ACT_DUMP, 32'hffff_ffff);
        issue(ACT_POP_BACK, 32'h0);
        issue(ACT_POP_FRONT, 32'h0);
        issue(ACT_REVERSE, 32'h0);
        issue(ACT_PUSH_BACK, 32'h7fff_ffff);
        issue(ACT_REVERSE, 32'h1234_5678);
        issue(ACT_DUMP, 32'h0);
        issue(ACT_PUSH_FRONT, 32'h8000_0000);
        issue(ACT_PUSH_BACK, 32'hffff_ffff);
        issue(ACT_PUSH_FRONT, 32'h0000_0000);
        issue(ACT_SPARE_LO, 32'h5555_5555);
        issue(ACT_DUMP, 32'h0);
        issue(ACT_REVERSE, 32'h0);
        issue(ACT_DUMP, 32'h0);
        issue(ACT_SPARE_HI, 32'haaaa_aaaa);
        issue(ACT_POP_FRONT, 32'h0);
        issue(ACT_POP_BACK, 32'h0);
        issue(ACT_DUMP, 32'h0);
        issue(ACT_POP_BACK, 32'h0);
        issue(ACT_POP_FRONT, 32'h0);
        issue(ACT_POP_FRONT, 32'h0);
        issue(ACT_DUMP, 32'h0);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            random_command((sent / 40) % 3, counted);
            if (counted)
                sent++;
        end
        s_tvalid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d result beats, deepest fill %0d",
                 commands, beats, deepest_fill);
        $display("%0d pushes dropped when full, %0d pops on an empty store",
                 full_drops, empty_pops);
        if (errors == 0)
            $display("[double_ended_buffer_with_reverse] OK");
        else
            $display("[double_ended_buffer_with_reverse] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/debr_pkg.sv
rtl/debr_addr_unit.sv
rtl/double_ended_buffer_with_reverse.sv
test/debr_checker.sv
test/double_ended_buffer_with_reverse_test.sv
